>>> hdl/segment_rect_intersect_test_defines.svh
// Assertion macros for the segment/rectangle hit test.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SEGMENT_RECT_INTERSECT_TEST_DEFINES_SVH
`define SEGMENT_RECT_INTERSECT_TEST_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define SRIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SRIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SRIT_ASSERT_NOW(lbl, ante, cons, msg)
`define SRIT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/srit_pkg.sv
package srit_pkg;

  // Outcode bits. An endpoint is below or above, and right or left, never both.
  localparam logic [3:0] CODE_INSIDE = 4'd0;
  localparam logic [3:0] CODE_BELOW  = 4'd8;
  localparam logic [3:0] CODE_ABOVE  = 4'd4;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_LEFT   = 4'd1;

  // Code sums that mean the segment spans the rectangle outright.
  localparam logic [4:0] SUM_VERT = 5'd12;
  localparam logic [4:0] SUM_HORZ = 5'd3;

  typedef logic [3:0] code_t;

  // Result of the outcode screen: decided says the crossing tests are not needed.
  typedef struct packed {
    logic decided;
    logic hit;
  } early_t;

endpackage

>>> hdl/srit_in_if.sv
interface srit_in_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] rect_left;
  logic signed [COORD_BITS-1:0] rect_top;
  logic signed [COORD_BITS-1:0] rect_right;
  logic signed [COORD_BITS-1:0] rect_bottom;

  modport source (
    output valid, start_x, start_y, end_x, end_y,
           rect_left, rect_top, rect_right, rect_bottom,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, end_x, end_y,
           rect_left, rect_top, rect_right, rect_bottom,
    output ready
  );
endinterface

>>> hdl/srit_out_if.sv
interface srit_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );
endinterface

>>> hdl/srit_outcode.sv
// Outcode of one point against the rectangle; points on an edge are inside.
// Below takes priority over above and right over left, so an inverted
// rectangle still yields a single code per axis.
module srit_outcode #(
  parameter int COORD_BITS = 24
) (
  input  logic signed [COORD_BITS-1:0] x,
  input  logic signed [COORD_BITS-1:0] y,
  input  logic signed [COORD_BITS-1:0] left,
  input  logic signed [COORD_BITS-1:0] top,
  input  logic signed [COORD_BITS-1:0] right,
  input  logic signed [COORD_BITS-1:0] bottom,
  output srit_pkg::code_t              code
);

  srit_pkg::code_t vert;
  srit_pkg::code_t horz;

  always_comb begin
    if (y > bottom) begin
      vert = srit_pkg::CODE_BELOW;
    end else if (y < top) begin
      vert = srit_pkg::CODE_ABOVE;
    end else begin
      vert = srit_pkg::CODE_INSIDE;
    end
    if (x > right) begin
      horz = srit_pkg::CODE_RIGHT;
    end else if (x < left) begin
      horz = srit_pkg::CODE_LEFT;
    end else begin
      horz = srit_pkg::CODE_INSIDE;
    end
  end

  assign code = vert | horz;

endmodule

>>> hdl/segment_rect_intersect_test.sv
// Pipeline: four register stages, the last one the output register.
// Throughput: one segment/rectangle pair per cycle while the output is not stalled.
// Reset: synchronous active-low rst_n empties every stage; no result is pending.
`include "segment_rect_intersect_test_defines.svh"
module segment_rect_intersect_test #(
  parameter int COORD_BITS = 24
) (
  input logic       clk,
  input logic       rst_n,
  srit_in_if.sink   in_ch,
  srit_out_if.source out_ch
);

  // Differences of two coordinates need one more bit, their products twice
  // that, and a difference of two products one bit more again.
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  // ---------------------------------------------------------------------------
  // Pipeline control. Each stage loads when it is empty or when the stage after
  // it loads, so bubbles collapse and a stalled output never drops a transfer.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic ld1, ld2, ld3, ld4;

  assign ld4 = !out_valid_r || out_ch.ready;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;

  assign in_ch.ready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= in_ch.valid;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
      if (ld3) begin
        v3_r <= v2_r;
      end
      if (ld4) begin
        out_valid_r <= v3_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: outcodes of both endpoints and the coordinate differences that the
  // crossing tests need. With a = start, b = end and the segment direction
  // (dx, dy), every edge test reduces to the products formed in stage 2.
  // ---------------------------------------------------------------------------
  srit_pkg::code_t c1, c2;

  srit_outcode #(.COORD_BITS(COORD_BITS)) u_code_start (
    .x      (in_ch.start_x),
    .y      (in_ch.start_y),
    .left   (in_ch.rect_left),
    .top    (in_ch.rect_top),
    .right  (in_ch.rect_right),
    .bottom (in_ch.rect_bottom),
    .code   (c1)
  );

  srit_outcode #(.COORD_BITS(COORD_BITS)) u_code_end (
    .x      (in_ch.end_x),
    .y      (in_ch.end_y),
    .left   (in_ch.rect_left),
    .top    (in_ch.rect_top),
    .right  (in_ch.rect_right),
    .bottom (in_ch.rect_bottom),
    .code   (c2)
  );

  srit_pkg::code_t c1_r, c2_r;
  logic signed [DW-1:0] dx_r, dy_r, wid_r, hgt_r;
  logic signed [DW-1:0] syb_r, syt_r, sxl_r, sxr_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      c1_r  <= c1;
      c2_r  <= c2;
      dx_r  <= $signed({in_ch.end_x[COORD_BITS-1], in_ch.end_x})
             - $signed({in_ch.start_x[COORD_BITS-1], in_ch.start_x});
      dy_r  <= $signed({in_ch.end_y[COORD_BITS-1], in_ch.end_y})
             - $signed({in_ch.start_y[COORD_BITS-1], in_ch.start_y});
      wid_r <= $signed({in_ch.rect_right[COORD_BITS-1], in_ch.rect_right})
             - $signed({in_ch.rect_left[COORD_BITS-1], in_ch.rect_left});
      hgt_r <= $signed({in_ch.rect_bottom[COORD_BITS-1], in_ch.rect_bottom})
             - $signed({in_ch.rect_top[COORD_BITS-1], in_ch.rect_top});
      syb_r <= $signed({in_ch.start_y[COORD_BITS-1], in_ch.start_y})
             - $signed({in_ch.rect_bottom[COORD_BITS-1], in_ch.rect_bottom});
      syt_r <= $signed({in_ch.start_y[COORD_BITS-1], in_ch.start_y})
             - $signed({in_ch.rect_top[COORD_BITS-1], in_ch.rect_top});
      sxl_r <= $signed({in_ch.start_x[COORD_BITS-1], in_ch.start_x})
             - $signed({in_ch.rect_left[COORD_BITS-1], in_ch.rect_left});
      sxr_r <= $signed({in_ch.start_x[COORD_BITS-1], in_ch.start_x})
             - $signed({in_ch.rect_right[COORD_BITS-1], in_ch.rect_right});
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the outcode screen and ten products.
  // The screen accepts when an endpoint is inside or the endpoints sit on
  // opposite sides of one axis inside the other's span, rejects when both lie
  // beyond a common edge, and otherwise leaves it to the crossing tests.
  // ---------------------------------------------------------------------------
  srit_pkg::early_t early;
  logic [4:0]       code_sum;

  assign code_sum = {1'b0, c1_r} + {1'b0, c2_r};

  always_comb begin
    if (c1_r == srit_pkg::CODE_INSIDE || c2_r == srit_pkg::CODE_INSIDE) begin
      early = '{decided: 1'b1, hit: 1'b1};
    end else if ((c1_r & c2_r) != srit_pkg::CODE_INSIDE) begin
      early = '{decided: 1'b1, hit: 1'b0};
    end else if (code_sum == srit_pkg::SUM_VERT || code_sum == srit_pkg::SUM_HORZ) begin
      early = '{decided: 1'b1, hit: 1'b1};
    end else begin
      early = '{decided: 1'b0, hit: 1'b0};
    end
  end

  srit_pkg::early_t early2_r;
  logic signed [PW-1:0] p_dyw_r, p_dxh_r;     // denominators
  logic signed [PW-1:0] p_sybw_r, p_sytw_r;   // r numerators, horizontal edges
  logic signed [PW-1:0] p_sxlh_r, p_sxrh_r;   // r numerators, vertical edges
  logic signed [PW-1:0] p_sybdx_r, p_sytdx_r; // s numerator terms
  logic signed [PW-1:0] p_sxldy_r, p_sxrdy_r;

  always_ff @(posedge clk) begin
    if (ld2) begin
      early2_r  <= early;
      p_dyw_r   <= dy_r * wid_r;
      p_dxh_r   <= dx_r * hgt_r;
      p_sybw_r  <= syb_r * wid_r;
      p_sytw_r  <= syt_r * wid_r;
      p_sxlh_r  <= sxl_r * hgt_r;
      p_sxrh_r  <= sxr_r * hgt_r;
      p_sybdx_r <= syb_r * dx_r;
      p_sytdx_r <= syt_r * dx_r;
      p_sxldy_r <= sxl_r * dy_r;
      p_sxrdy_r <= sxr_r * dy_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: denominators and numerators of the bottom, top, left and right edge tests.
  // Horizontal edges share den = -dy*w, vertical edges share den = dx*h.
  // The s numerator of the top edge and of the left edge is the same value.
  // ---------------------------------------------------------------------------
  function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] v);
    ext = $signed({v[PW-1], v});
  endfunction

  srit_pkg::early_t early3_r;
  logic signed [SW-1:0] den_h_r, den_v_r;
  logic signed [SW-1:0] nr_bot_r, nr_top_r, nr_lft_r, nr_rgt_r;
  logic signed [SW-1:0] ns_bot_r, ns_tl_r, ns_rgt_r;

  always_ff @(posedge clk) begin
    if (ld3) begin
      early3_r <= early2_r;
      den_h_r  <= -ext(p_dyw_r);
      den_v_r  <= ext(p_dxh_r);
      nr_bot_r <= ext(p_sybw_r);
      nr_top_r <= ext(p_sytw_r);
      nr_lft_r <= -ext(p_sxlh_r);
      nr_rgt_r <= -ext(p_sxrh_r);
      ns_bot_r <= ext(p_sybdx_r) - ext(p_sxldy_r);
      ns_tl_r  <= ext(p_sytdx_r) - ext(p_sxldy_r);
      ns_rgt_r <= ext(p_sytdx_r) - ext(p_sxrdy_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: a numerator lies in [0, den] when den is positive, and in
  // [den, 0] when den is negative; that is both parameters in [0, 1] without
  // a division. A zero denominator (parallel or collinear) never crosses.
  // ---------------------------------------------------------------------------
  function automatic logic in_span(input logic signed [SW-1:0] den,
                                   input logic signed [SW-1:0] num);
    logic pos;
    pos = !den[SW-1];
    in_span = pos ? (!num[SW-1] && num <= den) : (num <= 0 && num >= den);
  endfunction

  logic den_h_nz, den_v_nz;
  logic x_bot, x_top, x_lft, x_rgt;
  logic hit_nxt;

  assign den_h_nz = (den_h_r != '0);
  assign den_v_nz = (den_v_r != '0);

  assign x_bot = den_h_nz && in_span(den_h_r, nr_bot_r) && in_span(den_h_r, ns_bot_r);
  assign x_top = den_h_nz && in_span(den_h_r, nr_top_r) && in_span(den_h_r, ns_tl_r);
  assign x_lft = den_v_nz && in_span(den_v_r, nr_lft_r) && in_span(den_v_r, ns_tl_r);
  assign x_rgt = den_v_nz && in_span(den_v_r, nr_rgt_r) && in_span(den_v_r, ns_rgt_r);

  assign hit_nxt = early3_r.decided ? early3_r.hit : (x_bot || x_top || x_lft || x_rgt);

  logic hit_r;

  always_ff @(posedge clk) begin
    if (ld4) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = hit_r;

  // ---------------------------------------------------------------------------
  // Checks on the stage control.
  // ---------------------------------------------------------------------------
  `SRIT_ASSERT_NEXT(a_enter_stage1, in_ch.valid && in_ch.ready, v1_r, "accepted transfer did not reach stage 1")
  `SRIT_ASSERT_NEXT(a_hold_stage2, v2_r && !ld3, v2_r, "stage 2 item lost while stalled")
  `SRIT_ASSERT_NEXT(a_hold_stage3, v3_r && !ld4, v3_r, "stage 3 item lost while stalled")
  `SRIT_ASSERT_NOW(a_out_source, $rose(out_valid_r), $past(v3_r), "result appeared without a stage 3 item")

endmodule
